// File: rtl/core/harmonic_pair_repulsion_core_macros.svh
// Assertion macros for the harmonic pair repulsion core.
// Included by the core, which carries the concurrent checks; needs no other file.
`ifndef HARMONIC_PAIR_REPULSION_CORE_MACROS_SVH
`define HARMONIC_PAIR_REPULSION_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define HPRC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hprc: same-cycle check failed");
// Next-cycle implication check.
`define HPRC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hprc: next-cycle check failed");
`else
`define HPRC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define HPRC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/hprc_pkg.sv
// Shared constants of the harmonic pair repulsion core.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none
package hprc_pkg;

   // Width of a position, radius, stiffness or result word.
   localparam int unsigned WORD_W = 32;
   // Width of a packed cell coordinate word.
   localparam int unsigned CELL_W = 30;
   // Default fixed-point and cell field widths.
   localparam int unsigned FRAC_BITS_DEF = 16;
   localparam int unsigned CELL_BITS_DEF = 10;

endpackage
`default_nettype wire

// File: rtl/core/hprc_channels.sv
// Valid/ready channel interfaces for pair words in and result words out.
// Depends on hprc_pkg for the word widths.
`default_nettype none

// One particle pair per word.
interface hprc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hprc_pkg::WORD_W-1:0]   first_x;
   logic signed [hprc_pkg::WORD_W-1:0]   first_y;
   logic signed [hprc_pkg::WORD_W-1:0]   first_z;
   logic        [hprc_pkg::WORD_W-1:0]   first_radius;
   logic        [hprc_pkg::CELL_W-1:0]   first_cell;
   logic signed [hprc_pkg::WORD_W-1:0]   second_x;
   logic signed [hprc_pkg::WORD_W-1:0]   second_y;
   logic signed [hprc_pkg::WORD_W-1:0]   second_z;
   logic        [hprc_pkg::WORD_W-1:0]   second_radius;
   logic        [hprc_pkg::CELL_W-1:0]   second_cell;

   modport source (
      output valid, first_x, first_y, first_z, first_radius, first_cell,
             second_x, second_y, second_z, second_radius, second_cell,
      input  ready
   );
   modport sink (
      input  valid, first_x, first_y, first_z, first_radius, first_cell,
             second_x, second_y, second_z, second_radius, second_cell,
      output ready
   );
endinterface

// One force and energy result per word.
interface hprc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hprc_pkg::WORD_W-1:0]   push_x;
   logic signed [hprc_pkg::WORD_W-1:0]   push_y;
   logic signed [hprc_pkg::WORD_W-1:0]   push_z;
   logic        [hprc_pkg::WORD_W-1:0]   pair_energy;
   logic                                 overlapping;
   logic                                 neighbours;
   logic                                 degenerate;

   modport source (
      output valid, push_x, push_y, push_z, pair_energy, overlapping,
             neighbours, degenerate,
      input  ready
   );
   modport sink (
      input  valid, push_x, push_y, push_z, pair_energy, overlapping,
             neighbours, degenerate,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/core/harmonic_pair_repulsion_core.sv
// Throughput: one pair per cycle while results are taken. The depth is set by the
// bit-per-stage square root, the four fraction dividers and the force-scale divider;
// a stalled output freezes the whole pipeline.
// Reset clears every stage valid bit and loads the stiffness register with 1.0;
// data registers are not reset.
`default_nettype none
`include "harmonic_pair_repulsion_core_macros.svh"
module harmonic_pair_repulsion_core #(
   parameter int unsigned FRAC_BITS = hprc_pkg::FRAC_BITS_DEF,
   parameter int unsigned CELL_BITS = hprc_pkg::CELL_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   hprc_req_if.sink                     req_ch,
   hprc_rsp_if.source                   rsp_ch,
   input  wire                          csr_we,
   input  wire [hprc_pkg::WORD_W-1:0]   csr_wdata
);

   localparam int unsigned F    = FRAC_BITS;
   localparam int unsigned PW   = hprc_pkg::WORD_W;
   localparam int unsigned DW   = PW + 1;          // coordinate difference
   localparam int unsigned SGW  = PW + 1;          // radius sum
   localparam int unsigned SQW  = 2 * PW;          // one squared difference
   localparam int unsigned SUMW = 2 * PW + 2;      // squared distance, squared sigma
   localparam int unsigned RW   = SUMW / 2;        // root width and root stages
   localparam int unsigned SRW  = RW + 1;          // root remainder
   localparam int unsigned DRW  = SGW + 1;         // divider partial remainder
   localparam int unsigned QW   = F + 1;           // fraction in [0, 1.0]
   localparam int unsigned GW   = PW + F;          // force scale quotient
   localparam int unsigned FW   = GW + QW;         // force product
   localparam int unsigned NSTG = RW + QW + GW + 10;
   localparam logic [PW-1:0]        STIFF_RESET = PW'(1) << F;
   localparam logic [CELL_BITS:0]   CD_ONE      = (CELL_BITS + 1)'(1);

   typedef struct packed {
      logic                  nb;
      logic [2:0]            neg;
      logic [2:0][PW-1:0]    ad;
      logic [SGW-1:0]        sigma;
   } s1_type;

   typedef struct packed {
      s1_type                b;
      logic [2:0][SQW-1:0]   sq;
      logic [SUMW-1:0]       sig2;
   } s2_type;

   typedef struct packed {
      s1_type                b;
      logic [SUMW-1:0]       sum;
      logic [SUMW-1:0]       sig2;
   } s3_type;

   typedef struct packed {
      logic                  nb;
      logic                  ov;
      logic [2:0]            neg;
      logic [2:0][PW-1:0]    ad;
      logic [SGW-1:0]        sigma;
      logic [SUMW-1:0]       rad;
      logic [SRW-1:0]        rem;
      logic [RW-1:0]         root;
   } rt_type;

   typedef struct packed {
      logic                  nb;
      logic                  ov;
      logic                  dg;
      logic [2:0]            neg;
      logic [SGW-1:0]        sigma;
      logic [RW-1:0]         r;
      logic [3:0][DRW-1:0]   rem;
      logic [3:0][QW-1:0]    quo;
   } dv_type;

   typedef struct packed {
      logic                  nb;
      logic                  ov;
      logic                  dg;
      logic [2:0]            neg;
      logic [SGW-1:0]        sigma;
      logic [2:0][QW-1:0]    q;
      logic [2*QW-1:0]       u2f;
      logic [PW+QW-1:0]      mf;
   } m1_type;

   typedef struct packed {
      logic                  nb;
      logic                  ov;
      logic                  dg;
      logic [2:0]            neg;
      logic [SGW-1:0]        sigma;
      logic [2:0][QW-1:0]    q;
      logic [PW+QW-1:0]      ef;
      logic [PW-1:0]         m;
      logic [SGW-1:0]        rem;
      logic [GW-1:0]         quo;
   } gd_type;

   typedef struct packed {
      logic                  nb;
      logic                  ov;
      logic                  dg;
      logic [2:0]            neg;
      logic [PW-1:0]         energy;
      logic [2:0][PW+QW-1:0] plo;
      logic [2:0][F+QW-1:0]  phi;
   } fa_type;

   typedef struct packed {
      logic                  nb;
      logic                  ov;
      logic                  dg;
      logic [2:0]            neg;
      logic [PW-1:0]         energy;
      logic [2:0][PW-2:0]    mag;
   } fb_type;

   typedef struct packed {
      logic [2:0][PW-1:0]    push;
      logic [PW-1:0]         energy;
      logic                  ov;
      logic                  nb;
      logic                  dg;
   } out_type;

   logic                 adv;
   logic [NSTG-1:0]      vld_ff;
   logic [NSTG-1:0]      vld_in;
   logic [PW-1:0]        stiff_ff;

   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   rt_type   rt_ff [0:RW];
   rt_type   rt_in [0:RW];
   dv_type   dv_ff [0:QW];
   dv_type   dv_in [0:QW];
   m1_type   m1_ff, m1_in;
   gd_type   gd_ff [0:GW];
   gd_type   gd_in [0:GW];
   fa_type   fa_ff, fa_in;
   fb_type   fb_ff, fb_in;
   out_type  out_ff, out_in;

   // The whole pipeline moves unless a finished word is waiting at the output.
   assign adv          = !vld_ff[NSTG-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[NSTG-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stiffness register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
      end else if (csr_we) begin
         stiff_ff <= csr_wdata;
      end
   end

   // Stage 1: cell test, coordinate differences and radius sum.
   always_comb begin
      logic [2:0][PW-1:0]  pa;
      logic [2:0][PW-1:0]  pb;
      logic [CELL_BITS-1:0] ca;
      logic [CELL_BITS-1:0] cb;
      logic [CELL_BITS:0]   cd;
      logic [DW-1:0]        pd;
      pa = {req_ch.first_z, req_ch.first_y, req_ch.first_x};
      pb = {req_ch.second_z, req_ch.second_y, req_ch.second_x};
      s1_in.nb = 1'b1;
      for (int i = 0; i < 3; i++) begin
         ca = req_ch.first_cell[i*CELL_BITS +: CELL_BITS];
         cb = req_ch.second_cell[i*CELL_BITS +: CELL_BITS];
         cd = {ca[CELL_BITS-1], ca} - {cb[CELL_BITS-1], cb};
         if (cd != '0 && cd != CD_ONE && cd != '1) begin
            s1_in.nb = 1'b0;
         end
         pd = {pa[i][PW-1], pa[i]} - {pb[i][PW-1], pb[i]};
         s1_in.neg[i] = pd[DW-1];
         s1_in.ad[i]  = pd[DW-1] ? PW'(~pd + 1'b1) : pd[PW-1:0];
      end
      s1_in.sigma = {1'b0, req_ch.first_radius} + {1'b0, req_ch.second_radius};
   end

   // Stage 2: squares of the differences and of the radius sum.
   always_comb begin
      s2_in.b = s1_ff;
      for (int i = 0; i < 3; i++) begin
         s2_in.sq[i] = SQW'(s1_ff.ad[i]) * SQW'(s1_ff.ad[i]);
      end
      s2_in.sig2 = SUMW'(s1_ff.sigma) * SUMW'(s1_ff.sigma);
   end

   // Stage 3: squared distance.
   always_comb begin
      s3_in.b    = s2_ff.b;
      s3_in.sum  = SUMW'(s2_ff.sq[0]) + SUMW'(s2_ff.sq[1]) + SUMW'(s2_ff.sq[2]);
      s3_in.sig2 = s2_ff.sig2;
   end

   // Stage 4 and the root stages: overlap test, then one root bit per stage.
   always_comb begin
      logic [SRW+1:0] x;
      logic [SRW+1:0] t;
      rt_in[0].nb    = s3_ff.b.nb;
      rt_in[0].ov    = s3_ff.b.nb && (s3_ff.sig2 > s3_ff.sum);
      rt_in[0].neg   = s3_ff.b.neg;
      rt_in[0].ad    = s3_ff.b.ad;
      rt_in[0].sigma = s3_ff.b.sigma;
      rt_in[0].rad   = s3_ff.sum;
      rt_in[0].rem   = '0;
      rt_in[0].root  = '0;
      for (int j = 0; j < RW; j++) begin
         rt_in[j+1] = rt_ff[j];
         x = {rt_ff[j].rem, rt_ff[j].rad[SUMW-1-2*j -: 2]};
         t = (SRW+2)'({rt_ff[j].root, 2'b01});
         if (x >= t) begin
            rt_in[j+1].rem  = SRW'(x - t);
            rt_in[j+1].root = {rt_ff[j].root[RW-2:0], 1'b1};
         end else begin
            rt_in[j+1].rem  = x[SRW-1:0];
            rt_in[j+1].root = {rt_ff[j].root[RW-2:0], 1'b0};
         end
      end
   end

   // Divider set-up and four fraction dividers: lane 0 gives 1-R/sigma,
   // lanes 1 to 3 give |d|/R per axis. One quotient bit per stage.
   always_comb begin
      logic [DRW-1:0] x;
      logic [DRW-1:0] den;
      logic           ge;
      dv_in[0].nb    = rt_ff[RW].nb;
      dv_in[0].ov    = rt_ff[RW].ov;
      dv_in[0].dg    = rt_ff[RW].ov && (rt_ff[RW].root == '0);
      dv_in[0].neg   = rt_ff[RW].neg;
      dv_in[0].sigma = rt_ff[RW].sigma;
      dv_in[0].r     = rt_ff[RW].root;
      dv_in[0].rem[0] = {1'b0, rt_ff[RW].sigma - rt_ff[RW].root};
      for (int i = 0; i < 3; i++) begin
         dv_in[0].rem[i+1] = DRW'(rt_ff[RW].ad[i]);
      end
      dv_in[0].quo = '0;
      for (int j = 0; j < QW; j++) begin
         dv_in[j+1] = dv_ff[j];
         for (int l = 0; l < 4; l++) begin
            den = (l == 0) ? {1'b0, dv_ff[j].sigma} : {1'b0, dv_ff[j].r};
            x   = (j == 0) ? dv_ff[j].rem[l] : {dv_ff[j].rem[l][DRW-2:0], 1'b0};
            ge  = (x >= den);
            dv_in[j+1].rem[l] = ge ? (x - den) : x;
            dv_in[j+1].quo[l] = {dv_ff[j].quo[l][QW-2:0], ge};
         end
      end
   end

   // Products of the overlap fraction: u squared and k times u.
   always_comb begin
      m1_in.nb    = dv_ff[QW].nb;
      m1_in.ov    = dv_ff[QW].ov;
      m1_in.dg    = dv_ff[QW].dg;
      m1_in.neg   = dv_ff[QW].neg;
      m1_in.sigma = dv_ff[QW].sigma;
      for (int i = 0; i < 3; i++) begin
         m1_in.q[i] = dv_ff[QW].quo[i+1];
      end
      m1_in.u2f = (2*QW)'(dv_ff[QW].quo[0]) * (2*QW)'(dv_ff[QW].quo[0]);
      m1_in.mf  = (PW+QW)'(stiff_ff) * (PW+QW)'(dv_ff[QW].quo[0]);
   end

   // Energy product, then the force scale k*u/sigma by long division.
   always_comb begin
      logic [GW-1:0]  dvd;
      logic [DRW-1:0] x;
      logic [DRW-1:0] den;
      logic           ge;
      gd_in[0].nb    = m1_ff.nb;
      gd_in[0].ov    = m1_ff.ov;
      gd_in[0].dg    = m1_ff.dg;
      gd_in[0].neg   = m1_ff.neg;
      gd_in[0].sigma = m1_ff.sigma;
      gd_in[0].q     = m1_ff.q;
      gd_in[0].ef    = (PW+QW)'(stiff_ff) * (PW+QW)'(m1_ff.u2f[F +: QW]);
      gd_in[0].m     = m1_ff.mf[F +: PW];
      gd_in[0].rem   = '0;
      gd_in[0].quo   = '0;
      for (int j = 0; j < GW; j++) begin
         gd_in[j+1] = gd_ff[j];
         dvd = {gd_ff[j].m, {F{1'b0}}};
         x   = {gd_ff[j].rem, dvd[GW-1-j]};
         den = {1'b0, gd_ff[j].sigma};
         ge  = (x >= den);
         gd_in[j+1].rem = ge ? SGW'(x - den) : x[SGW-1:0];
         gd_in[j+1].quo = {gd_ff[j].quo[GW-2:0], ge};
      end
   end

   // Force partial products: scale split into low word and high part.
   always_comb begin
      fa_in.nb     = gd_ff[GW].nb;
      fa_in.ov     = gd_ff[GW].ov;
      fa_in.dg     = gd_ff[GW].dg;
      fa_in.neg    = gd_ff[GW].neg;
      fa_in.energy = gd_ff[GW].ef[F+1 +: PW];
      for (int i = 0; i < 3; i++) begin
         fa_in.plo[i] = (PW+QW)'(gd_ff[GW].quo[PW-1:0]) * (PW+QW)'(gd_ff[GW].q[i]);
         fa_in.phi[i] = (F+QW)'(gd_ff[GW].quo[GW-1:PW]) * (F+QW)'(gd_ff[GW].q[i]);
      end
   end

   // Force magnitude, clamped to the largest positive word.
   always_comb begin
      logic [FW-1:0]    full;
      logic [PW+QW-1:0] mw;
      fb_in.nb     = fa_ff.nb;
      fb_in.ov     = fa_ff.ov;
      fb_in.dg     = fa_ff.dg;
      fb_in.neg    = fa_ff.neg;
      fb_in.energy = fa_ff.energy;
      for (int i = 0; i < 3; i++) begin
         full = {fa_ff.phi[i], {PW{1'b0}}} + FW'(fa_ff.plo[i]);
         mw   = full[FW-1:F];
         fb_in.mag[i] = (|mw[PW+QW-1:PW-1]) ? '1 : mw[PW-2:0];
      end
   end

   // Output word: signs applied, results zeroed outside an overlap, push zeroed if degenerate.
   always_comb begin
      logic [PW-1:0] pm;
      for (int i = 0; i < 3; i++) begin
         pm = {1'b0, fb_ff.mag[i]};
         if (fb_ff.ov && !fb_ff.dg) begin
            out_in.push[i] = fb_ff.neg[i] ? (~pm + 1'b1) : pm;
         end else begin
            out_in.push[i] = '0;
         end
      end
      out_in.energy = fb_ff.ov ? fb_ff.energy : '0;
      out_in.ov     = fb_ff.ov;
      out_in.nb     = fb_ff.nb;
      out_in.dg     = fb_ff.dg;
   end

   // Data registers of every stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         for (int j = 0; j <= RW; j++) begin
            rt_ff[j] <= rt_in[j];
         end
         for (int j = 0; j <= QW; j++) begin
            dv_ff[j] <= dv_in[j];
         end
         m1_ff <= m1_in;
         for (int j = 0; j <= GW; j++) begin
            gd_ff[j] <= gd_in[j];
         end
         fa_ff  <= fa_in;
         fb_ff  <= fb_in;
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid       = vld_ff[NSTG-1];
   assign rsp_ch.push_x      = out_ff.push[0];
   assign rsp_ch.push_y      = out_ff.push[1];
   assign rsp_ch.push_z      = out_ff.push[2];
   assign rsp_ch.pair_energy = out_ff.energy;
   assign rsp_ch.overlapping = out_ff.ov;
   assign rsp_ch.neighbours  = out_ff.nb;
   assign rsp_ch.degenerate  = out_ff.dg;

   // Checks on result consistency and on stall behaviour.
   `HPRC_ASSERT_IMPLY(a_degenerate_overlaps, clock, reset, rsp_ch.valid && rsp_ch.degenerate, rsp_ch.overlapping)
   `HPRC_ASSERT_IMPLY(a_overlap_neighbours, clock, reset, rsp_ch.valid && rsp_ch.overlapping, rsp_ch.neighbours)
   `HPRC_ASSERT_IMPLY(a_apart_is_quiet, clock, reset, rsp_ch.valid && !rsp_ch.overlapping, rsp_ch.pair_energy == '0 && rsp_ch.push_x == '0 && rsp_ch.push_y == '0 && rsp_ch.push_z == '0)
   `HPRC_ASSERT_IMPLY(a_degenerate_no_push, clock, reset, rsp_ch.valid && rsp_ch.degenerate, rsp_ch.push_x == '0 && rsp_ch.push_y == '0 && rsp_ch.push_z == '0)
   `HPRC_ASSERT_NEXT(a_stall_freezes, clock, reset, !adv, vld_ff == $past(vld_ff))

endmodule
`default_nettype wire
